FILE: hdl/mtfr_pkg.sv
// Shared types and constants for the Modbus TCP frame receiver.
package mtfr_pkg;

	localparam int unsigned APB_DW   = 32;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned REG_IDXW = 1;

	typedef enum logic [REG_IDXW-1:0] {
		REG_TRANSACTION_ID = 1'b0,
		REG_UNIT_ID        = 1'b1
	} reg_idx_t;

	localparam logic [15:0] TID_RESET  = 16'h0001;
	localparam logic [7:0]  UNIT_RESET = 8'h01;
	localparam logic [7:0]  PROTO_BYTE = 8'h00;
	localparam logic [15:0] MIN_LENGTH = 16'd2;

	typedef struct packed {
		logic [15:0] transaction_id;
		logic [7:0]  unit_id;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [7:0]  function_code;
		logic        frame_done;
		logic        header_error;
		logic        length_error;
	} result_t;

endpackage

FILE: hdl/mtfr_if.sv
// Valid/ready channel interfaces for received bytes and parse results.
interface mtfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mtfr_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  function_code;
	logic        frame_done;
	logic        header_error;
	logic        length_error;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_index, output function_code, output frame_done,
		output header_error, output length_error, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_index, input function_code, input frame_done,
		input header_error, input length_error, output ready);
endinterface

FILE: hdl/modbus_tcp_frame_receiver_top.sv
// Top level of the Modbus TCP frame receiver.
// Path: an accepted byte is held in the input register and is parsed into the result
// register when that register is free or its result is taken.
// Throughput: one byte per cycle while results are taken; a stalled result holds the
// input once one more request waits in the input register.
// Reset: arst_n clears control and parse state; hunting restarts and both ids return to 1.
module modbus_tcp_frame_receiver_top
	import mtfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	mtfr_in_if.sink           rx,
	mtfr_out_if.source        res
);

	cfg_t    cfg;
	result_t out_res;

	mtfr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_res   (out_res)
	);

	assign res.payload_valid = out_res.payload_valid;
	assign res.payload_byte  = out_res.payload_byte;
	assign res.payload_index = out_res.payload_index;
	assign res.function_code = out_res.function_code;
	assign res.frame_done    = out_res.frame_done;
	assign res.header_error  = out_res.header_error;
	assign res.length_error  = out_res.length_error;

endmodule

FILE: hdl/mtfr_cfg_regs.sv
// APB configuration registers: expected transaction id and unit id.
module mtfr_cfg_regs
	import mtfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[APB_AW-1 -: REG_IDXW]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transaction_id <= TID_RESET;
			cfg_q.unit_id        <= UNIT_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_TRANSACTION_ID: cfg_q.transaction_id <= pwdata[15:0];
				REG_UNIT_ID:        cfg_q.unit_id        <= pwdata[7:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TRANSACTION_ID: prdata = {{(APB_DW-16){1'b0}}, cfg_q.transaction_id};
			REG_UNIT_ID:        prdata = {{(APB_DW-8){1'b0}}, cfg_q.unit_id};
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: hdl/mtfr_parser.sv
// Byte input register, MBAP header/payload parse state and result register.
module mtfr_parser
	import mtfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_res
);

	typedef enum logic [3:0] {
		PH_TID_HI   = 4'd0,
		PH_TID_LO   = 4'd1,
		PH_PROTO_HI = 4'd2,
		PH_PROTO_LO = 4'd3,
		PH_LEN_HI   = 4'd4,
		PH_LEN_LO   = 4'd5,
		PH_UNIT     = 4'd6,
		PH_FUNC     = 4'd7,
		PH_DATA     = 4'd8
	} phase_t;

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	// result stage
	logic       vld_s2;
	result_t    res_s2;

	phase_t      phase_q, phase_d;
	logic [15:0] remain_q, remain_d;
	logic [7:0]  func_q, func_d;
	logic [15:0] count_q, count_d;
	logic [15:0] remain_dec;
	logic [15:0] len_full;
	result_t     res_d;
	logic        adv_s1;

	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;
	assign out_valid = vld_s2;
	assign out_res  = res_s2;

	assign remain_dec = remain_q - 16'd1;
	assign len_full   = {remain_q[15:8], byte_s1};

	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		func_d   = func_q;
		count_d  = count_q;
		res_d    = '0;
		case (phase_q)
			PH_TID_LO: begin
				if (byte_s1 == cfg.transaction_id[7:0]) begin
					phase_d = PH_PROTO_HI;
				end else begin
					res_d.header_error = 1'b1;
					phase_d = PH_TID_HI;
				end
			end
			PH_PROTO_HI, PH_PROTO_LO: begin
				if (byte_s1 == PROTO_BYTE) begin
					phase_d = (phase_q == PH_PROTO_HI) ? PH_PROTO_LO : PH_LEN_HI;
				end else begin
					res_d.header_error = 1'b1;
					phase_d = PH_TID_HI;
				end
			end
			PH_LEN_HI: begin
				remain_d = {byte_s1, 8'h00};
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				remain_d = len_full;
				if (len_full < MIN_LENGTH) begin
					res_d.length_error = 1'b1;
					phase_d = PH_TID_HI;
				end else begin
					phase_d = PH_UNIT;
				end
			end
			PH_UNIT: begin
				if (byte_s1 == cfg.unit_id) begin
					remain_d = remain_dec;
					phase_d  = PH_FUNC;
				end else begin
					res_d.header_error = 1'b1;
					phase_d = PH_TID_HI;
				end
			end
			PH_FUNC: begin
				func_d   = byte_s1;
				count_d  = '0;
				remain_d = remain_dec;
				if (remain_dec == 16'd0) begin
					res_d.frame_done = 1'b1;
					phase_d = PH_TID_HI;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = byte_s1;
				res_d.payload_index = count_q;
				count_d  = count_q + 16'd1;
				remain_d = remain_dec;
				if (remain_dec == 16'd0) begin
					res_d.frame_done = 1'b1;
					phase_d = PH_TID_HI;
				end
			end
			default: begin
				// hunting; unused phase codes hunt too
				phase_d = (byte_s1 == cfg.transaction_id[15:8]) ? PH_TID_LO : PH_TID_HI;
			end
		endcase
		res_d.function_code = func_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			phase_q  <= PH_TID_HI;
			remain_q <= '0;
			func_q   <= '0;
			count_q  <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s1) begin
				vld_s2   <= 1'b1;
				phase_q  <= phase_d;
				remain_q <= remain_d;
				func_q   <= func_d;
				count_q  <= count_d;
			end else if (out_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

FILE: hdl/mtfr_checker.sv
// Port-level checks on the result channel of the frame receiver, with bind.
module mtfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic [15:0] payload_index,
	input logic        frame_done,
	input logic        header_error,
	input logic        length_error
);

	// a result is data, a header error or a length error, never two of them
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({payload_valid, header_error, length_error}))
		else $error("result carries conflicting flags");

	a_done_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> !header_error && !length_error)
		else $error("frame done together with an error");

	a_idle_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !payload_valid |-> payload_byte == 8'h00 && payload_index == 16'h0000)
		else $error("payload fields nonzero on a non-data result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_index)
			&& $stable(payload_byte) && $stable(frame_done))
		else $error("stalled result changed");

endmodule

bind modbus_tcp_frame_receiver_top mtfr_checker u_mtfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.payload_valid (res.payload_valid),
	.payload_byte  (res.payload_byte),
	.payload_index (res.payload_index),
	.frame_done    (res.frame_done),
	.header_error  (res.header_error),
	.length_error  (res.length_error)
);

FILE: bench/tb_modbus_tcp_frame_receiver_top.sv
`timescale 1ns / 1ps
// Modbus TCP frame receiver testbench: directed and random byte streams checked by a frame parser.
module tb_modbus_tcp_frame_receiver_top;
	import mtfr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASE_BYTES = 280;

	typedef enum logic [3:0] {
		HUNT_TID_HI,
		GET_TID_LO,
		GET_PROTO_HI,
		GET_PROTO_LO,
		GET_LEN_HI,
		GET_LEN_LO,
		GET_UNIT,
		GET_FUNC,
		GET_DATA
	} frame_phase_t;

	// Tracks the frame parse of every accepted byte and holds the results still due.
	class mbap_tracker;
		logic [15:0]  cfg_tid;
		logic [7:0]   cfg_unit;
		frame_phase_t phase;
		logic [15:0]  bytes_left;
		logic [7:0]   func_code;
		logic [15:0]  data_count;
		result_t      due_results[$];
		int unsigned  failures;
		int unsigned  frames_seen;
		int unsigned  data_seen;
		int unsigned  hdr_errs_seen;
		int unsigned  len_errs_seen;

		function new();
			cfg_tid       = TID_RESET;
			cfg_unit      = UNIT_RESET;
			phase         = HUNT_TID_HI;
			bytes_left    = '0;
			func_code     = '0;
			data_count    = '0;
			failures      = 0;
			frames_seen   = 0;
			data_seen     = 0;
			hdr_errs_seen = 0;
			len_errs_seen = 0;
		endfunction

		function void set_config(reg_idx_t idx, logic [APB_DW-1:0] value);
			if (idx == REG_TRANSACTION_ID)
				cfg_tid = value[15:0];
			else
				cfg_unit = value[7:0];
		endfunction

		// One request in, one result due.
		function void take_byte(logic [7:0] b);
			result_t r;
			r = '0;
			case (phase)
				GET_TID_LO: begin
					if (b == cfg_tid[7:0]) begin
						phase = GET_PROTO_HI;
					end else begin
						r.header_error = 1'b1;
						phase = HUNT_TID_HI;
					end
				end
				GET_PROTO_HI, GET_PROTO_LO: begin
					if (b != PROTO_BYTE) begin
						r.header_error = 1'b1;
						phase = HUNT_TID_HI;
					end else if (phase == GET_PROTO_HI) begin
						phase = GET_PROTO_LO;
					end else begin
						phase = GET_LEN_HI;
					end
				end
				GET_LEN_HI: begin
					bytes_left = {b, 8'h00};
					phase = GET_LEN_LO;
				end
				GET_LEN_LO: begin
					bytes_left = {bytes_left[15:8], b};
					if (bytes_left < MIN_LENGTH) begin
						r.length_error = 1'b1;
						phase = HUNT_TID_HI;
					end else begin
						phase = GET_UNIT;
					end
				end
				GET_UNIT: begin
					if (b == cfg_unit) begin
						bytes_left = bytes_left - 16'd1;
						phase = GET_FUNC;
					end else begin
						r.header_error = 1'b1;
						phase = HUNT_TID_HI;
					end
				end
				GET_FUNC: begin
					func_code  = b;
					data_count = '0;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'd0) begin
						r.frame_done = 1'b1;
						phase = HUNT_TID_HI;
					end else begin
						phase = GET_DATA;
					end
				end
				GET_DATA: begin
					r.payload_valid = 1'b1;
					r.payload_byte  = b;
					r.payload_index = data_count;
					data_count = data_count + 16'd1;
					bytes_left = bytes_left - 16'd1;
					if (bytes_left == 16'd0) begin
						r.frame_done = 1'b1;
						phase = HUNT_TID_HI;
					end
				end
				default: begin
					// mismatches while hunting are dropped silently
					if (b == cfg_tid[15:8])
						phase = GET_TID_LO;
					else
						phase = HUNT_TID_HI;
				end
			endcase
			r.function_code = func_code;
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void match_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result with no request pending, actual %p", $time, got);
				failures++;
				return;
			end
			want = due_results.pop_front();
			compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
			compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
			compare_field("payload_index", want.payload_index, got.payload_index);
			compare_field("function_code", 16'(want.function_code), 16'(got.function_code));
			compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
			compare_field("header_error", 16'(want.header_error), 16'(got.header_error));
			compare_field("length_error", 16'(want.length_error), 16'(got.length_error));
			if (want.frame_done)
				frames_seen++;
			if (want.payload_valid)
				data_seen++;
			if (want.header_error)
				hdr_errs_seen++;
			if (want.length_error)
				len_errs_seen++;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	mtfr_in_if  rx_ch ();
	mtfr_out_if res_ch ();

	mbap_tracker tracker;
	bit          no_idle;
	int unsigned stall_left;
	int unsigned cycles;
	int unsigned bytes_sent;
	int unsigned settings_used;

	modbus_tcp_frame_receiver_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.res     (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short pauses, now and then a long one
	function automatic int unsigned idle_span();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned frame_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 88)
			return $urandom_range(2, 10);
		if (r < 98)
			return $urandom_range(11, 64);
		return $urandom_range(65, 300);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 3) == 0)
			gap = idle_span();
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		tracker.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (tracker.due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] mask;
		logic [APB_DW-1:0] seen;
		mask = (idx == REG_TRANSACTION_ID) ? 32'h0000_ffff : 32'h0000_00ff;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_config(idx, value);
		// read back through the same port
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((seen & mask) !== (value & mask)) begin
			$display("%0t: readback of %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, idx.name(), value & mask, seen & mask);
			tracker.failures++;
		end
	endtask

	task automatic send_header(input logic [15:0] len);
		push_byte(tracker.cfg_tid[15:8]);
		push_byte(tracker.cfg_tid[7:0]);
		push_byte(PROTO_BYTE);
		push_byte(PROTO_BYTE);
		push_byte(len[15:8]);
		push_byte(len[7:0]);
	endtask

	// Mostly well-formed frames with random content, the rest noise and broken frames.
	task automatic send_traffic(input int unsigned quota, input bit hold_midway);
		int unsigned start;
		int unsigned kind;
		int unsigned len;
		int unsigned n;
		int unsigned i;
		bit          held;
		start = bytes_sent;
		held  = 1'b0;
		while (bytes_sent - start < quota) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			if (hold_midway && !held && bytes_sent - start > quota / 2) begin
				wait_for_results();
				held = 1'b1;
			end
			kind = $urandom_range(0, 99);
			len  = frame_len();
			if (kind < 70) begin
				send_header(16'(len));
				push_byte(tracker.cfg_unit);
				push_byte(8'($urandom_range(0, 255)));
				for (i = 0; i + 2 < len; i++)
					push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 78) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 82) begin
				push_byte(tracker.cfg_tid[15:8]);
				push_byte(tracker.cfg_tid[7:0] ^ 8'($urandom_range(1, 255)));
			end else if (kind < 86) begin
				push_byte(tracker.cfg_tid[15:8]);
				push_byte(tracker.cfg_tid[7:0]);
				if ($urandom_range(0, 1))
					push_byte(PROTO_BYTE);
				push_byte(PROTO_BYTE ^ 8'($urandom_range(1, 255)));
			end else if (kind < 90) begin
				send_header(16'($urandom_range(0, 1)));
			end else if (kind < 94) begin
				send_header(16'(len));
				push_byte(tracker.cfg_unit ^ 8'($urandom_range(1, 255)));
			end else begin
				// cut short; the next bytes land in the data of this frame
				send_header(16'(len));
				push_byte(tracker.cfg_unit);
				push_byte(8'($urandom_range(0, 255)));
				n = (len > 2) ? $urandom_range(0, len - 3) : 0;
				for (i = 0; i < n; i++)
					push_byte(8'($urandom_range(0, 255)));
			end
		end
		no_idle = 1'b0;
	endtask

	// sink side: random back-pressure
	always @(negedge clk) begin
		if (no_idle) begin
			res_ch.ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0)
				stall_left = idle_span();
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.payload_valid = res_ch.payload_valid;
			got.payload_byte  = res_ch.payload_byte;
			got.payload_index = res_ch.payload_index;
			got.function_code = res_ch.function_code;
			got.frame_done    = res_ch.frame_done;
			got.header_error  = res_ch.header_error;
			got.length_error  = res_ch.length_error;
			tracker.match_result(got);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		// hunting noise, length two, one data byte, length zero,
		// bad transaction low byte, bad protocol byte
		logic [7:0] directed [30];
		logic [15:0] tid;
		logic [7:0]  unit;
		int unsigned i;
		int unsigned s;
		directed = '{8'h80,
			8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h2b,
			8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'hff,
			8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00,
			8'h00, 8'h01, 8'h00, 8'h42};
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		no_idle       = 1'b0;
		stall_left    = 0;
		cycles        = 0;
		bytes_sent    = 0;
		settings_used = 1;
		tracker       = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		for (i = 0; i < 30; i++)
			push_byte(directed[i]);
		wait_for_results();

		for (s = 0; s < 6; s++) begin
			case (s)
				0: begin
					tid  = 16'h0000;
					unit = 8'h00;
				end
				1: begin
					tid  = 16'hffff;
					unit = 8'hff;
				end
				4: begin
					tid  = TID_RESET;
					unit = UNIT_RESET;
				end
				default: begin
					tid  = 16'($urandom_range(0, 65535));
					unit = 8'($urandom_range(0, 255));
				end
			endcase
			write_reg(REG_TRANSACTION_ID, 32'(tid));
			write_reg(REG_UNIT_ID, 32'(unit));
			settings_used++;
			send_traffic(PHASE_BYTES, s == 2);
			wait_for_results();
		end

		$display("Covered %0d bytes under %0d id settings: %0d frames, %0d payload bytes,",
			bytes_sent, settings_used, tracker.frames_seen, tracker.data_seen);
		$display("%0d header errors and %0d length errors.",
			tracker.hdr_errs_seen, tracker.len_errs_seen);
		if (tracker.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
